FILE: rtl/keyed_fixed_window_rate_limiter_defines.svh
// Assertion macros for the rate limiter checker.
`ifndef KEYED_FIXED_WINDOW_RATE_LIMITER_DEFINES_SVH
`define KEYED_FIXED_WINDOW_RATE_LIMITER_DEFINES_SVH
// Assert a property on the rising clock edge, disabled during reset.
`define KFW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Assert that a condition in one cycle is followed by another in the next cycle.
`define KFW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: rtl/kfwrl_pkg.sv
// Package with shared types and constants of the keyed fixed-window rate limiter.
package kfwrl_pkg;
	localparam int TableDepth = 64;
	localparam logic [16:0] CountMax = 17'h1FFFF;
	localparam logic [1:0] ActCheck = 2'd0;
	localparam logic [1:0] ActSuccess = 2'd1;
	localparam logic [1:0] ActClear = 2'd2;
	localparam logic [1:0] RegEnable = 2'd0;
	localparam logic [1:0] RegWindow = 2'd1;
	localparam logic [1:0] RegSrcLimit = 2'd2;
	localparam logic [1:0] RegAccLimit = 2'd3;

	// Command broadcast along a chain of cells.
	typedef struct packed {
		logic purge;
		logic record;
		logic remove;
		logic clear;
		logic [63:0] key;
		logic [31:0] now;
		logic [16:0] win;
	} kfwrl_cmd_t;

	// Result flowing along the chain: hit search plus first free slot.
	typedef struct packed {
		logic hit;
		logic free;
		logic [16:0] count;
		logic [31:0] start;
	} kfwrl_link_t;
endpackage

FILE: rtl/kfwrl_cell.sv
// One table entry: key, window start and count, with its own compare.
module kfwrl_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kfwrl_pkg::kfwrl_cmd_t         cmd,
	input  logic                         table_hit,
	input  kfwrl_pkg::kfwrl_link_t        link_in,
	output kfwrl_pkg::kfwrl_link_t        link_out,
	output logic                         hit_here
);
	logic valid_q;
	logic [63:0] key_q;
	logic [31:0] start_q;
	logic [16:0] count_q;
	logic match;
	logic take;
	logic expired;
	logic [16:0] cnt_inc;

	assign match = valid_q && key_q == cmd.key;
	assign hit_here = match;
	assign take = !valid_q && !link_in.hit && !link_in.free;
	assign expired = cmd.now >= start_q && ((cmd.now - start_q) >= {15'd0, cmd.win});
	assign cnt_inc = (count_q == kfwrl_pkg::CountMax) ? count_q : count_q + 17'd1;

	always_comb begin
		link_out = link_in;
		if (!link_in.hit && match) begin
			link_out.hit = 1'b1;
			link_out.count = cnt_inc;
			link_out.start = start_q;
		end else if (take) begin
			link_out.free = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.purge) begin
			if (valid_q && expired) valid_q <= 1'b0;
		end else if (cmd.remove) begin
			if (match && !link_in.hit) valid_q <= 1'b0;
		end else if (cmd.record) begin
			if (take && !table_hit) valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.record && !cmd.purge && !cmd.clear && !cmd.remove) begin
			if (!link_in.hit && match) begin
				count_q <= cnt_inc;
			end else if (take && !table_hit) begin
				key_q <= cmd.key;
				start_q <= cmd.now;
				count_q <= 17'd1;
			end
		end
	end
endmodule

FILE: rtl/kfwrl_table.sv
// One keyed table: a chain of entry cells and the lookup outcome.
module kfwrl_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kfwrl_pkg::kfwrl_cmd_t  cmd,
	output logic [16:0]           count,
	output logic [31:0]           start
);
	kfwrl_pkg::kfwrl_link_t chain [kfwrl_pkg::TableDepth+1];
	logic [kfwrl_pkg::TableDepth-1:0] match_vec;
	logic any_hit;

	assign chain[0] = '0;
	assign any_hit = |match_vec;

	for (genvar i = 0; i < kfwrl_pkg::TableDepth; i++) begin : g_cell
		kfwrl_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .table_hit(any_hit),
			.link_in(chain[i]), .link_out(chain[i+1]), .hit_here(match_vec[i])
		);
	end

	always_comb begin
		if (chain[kfwrl_pkg::TableDepth].hit) begin
			count = chain[kfwrl_pkg::TableDepth].count;
			start = chain[kfwrl_pkg::TableDepth].start;
		end else if (chain[kfwrl_pkg::TableDepth].free) begin
			count = 17'd1;
			start = cmd.now;
		end else begin
			count = kfwrl_pkg::CountMax;
			start = cmd.now;
		end
	end
endmodule

FILE: rtl/keyed_fixed_window_rate_limiter.sv
// Top level of the keyed fixed-window rate limiter.
// channel | valid     | ready     | payload
// input   | in_valid  | in_ready  | action source_id account_id now_time
// output  | out_valid | out_ready | blocked retry_secs
// An enabled check makes a purge pass over all cells, then a record pass.
// Success, clear, unused actions and disabled checks make a single pass in the cell row.
// The result waits in an output register; a new request enters when it is free or
// draining, and never during the record pass.
// Reset empties both tables at once through per-cell valid flops.
module keyed_fixed_window_rate_limiter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [63:0] source_id,
	input  logic [63:0] account_id,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        blocked,
	output logic [15:0] retry_secs,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRecord = 2'd1;

	logic [1:0] state_q;
	logic enable_q;
	logic [15:0] window_q, src_limit_q, acc_limit_q;
	logic [1:0] act_q;
	logic [63:0] src_q, acc_q;
	logic [31:0] now_q;
	logic out_valid_q, blocked_q;
	logic [15:0] retry_q;
	kfwrl_pkg::kfwrl_cmd_t src_cmd, acc_cmd;
	logic [16:0] s_cnt, a_cnt, win, s_lim, a_lim;
	logic [31:0] s_start, a_start, b_start, elapsed;
	logic s_ex, a_ex, take, go_record;
	logic [15:0] retry;

	assign win = (window_q == 16'd0) ? 17'd1 : {1'b0, window_q};
	assign s_lim = (src_limit_q == 16'd0) ? 17'd1 : {1'b0, src_limit_q};
	assign a_lim = (acc_limit_q == 16'd0) ? 17'd1 : {1'b0, acc_limit_q};

	assign in_ready = state_q == StIdle && (!out_valid_q || out_ready);
	assign take = in_valid && in_ready;
	assign go_record = action == kfwrl_pkg::ActCheck && enable_q;

	always_comb begin
		src_cmd = '0;
		acc_cmd = '0;
		src_cmd.now = now_q;
		acc_cmd.now = now_q;
		src_cmd.win = win;
		acc_cmd.win = win;
		src_cmd.key = src_q;
		acc_cmd.key = acc_q;
		if (state_q == StIdle && take) begin
			src_cmd.now = now_time;
			acc_cmd.now = now_time;
			acc_cmd.key = account_id;
			unique case (action)
				kfwrl_pkg::ActCheck: begin
					src_cmd.purge = enable_q;
					acc_cmd.purge = enable_q;
				end
				kfwrl_pkg::ActSuccess: acc_cmd.remove = 1'b1;
				kfwrl_pkg::ActClear: begin
					src_cmd.clear = 1'b1;
					acc_cmd.clear = 1'b1;
				end
				default: ;
			endcase
		end else if (state_q == StRecord) begin
			src_cmd.record = 1'b1;
			acc_cmd.record = 1'b1;
		end
	end

	kfwrl_table u_src (.clk(clk), .arst_n(arst_n), .cmd(src_cmd), .count(s_cnt), .start(s_start));
	kfwrl_table u_acc (.clk(clk), .arst_n(arst_n), .cmd(acc_cmd), .count(a_cnt), .start(a_start));

	assign s_ex = s_cnt > s_lim;
	assign a_ex = a_cnt > a_lim;
	assign b_start = s_ex ? s_start : a_start;
	assign elapsed = (now_q >= b_start) ? now_q - b_start : 32'd0;
	assign retry = (elapsed >= {15'd0, win}) ? 16'd1 : 16'(win - elapsed[16:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			out_valid_q <= 1'b0;
			enable_q <= 1'b0;
			window_q <= 16'd60;
			src_limit_q <= 16'd5;
			acc_limit_q <= 16'd5;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					kfwrl_pkg::RegEnable: enable_q <= cfg_data[0];
					kfwrl_pkg::RegWindow: window_q <= cfg_data;
					kfwrl_pkg::RegSrcLimit: src_limit_q <= cfg_data;
					kfwrl_pkg::RegAccLimit: acc_limit_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				StIdle: begin
					if (take && go_record) state_q <= StRecord;
				end
				StRecord: state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
			if (state_q == StRecord || (take && !go_record)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			act_q <= action;
			src_q <= source_id;
			acc_q <= account_id;
			now_q <= now_time;
			blocked_q <= 1'b0;
			retry_q <= 16'd0;
		end else if (state_q == StRecord) begin
			blocked_q <= s_ex || a_ex;
			retry_q <= (s_ex || a_ex) ? retry : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign blocked = blocked_q && act_q == kfwrl_pkg::ActCheck;
	assign retry_secs = retry_q;
endmodule

FILE: rtl/kfwrl_checker.sv
// Port-level checker for the rate limiter, bound to the top level.
`include "keyed_fixed_window_rate_limiter_defines.svh"
module kfwrl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        blocked,
	input logic [15:0] retry_secs
);
	`KFW_ASSERT(a_retry_zero, !out_valid || blocked || retry_secs == 16'd0, "retry without block")
	`KFW_ASSERT(a_retry_pos, !out_valid || !blocked || retry_secs != 16'd0, "blocked with zero retry")
	`KFW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(blocked) && $stable(retry_secs), "result dropped")
	`KFW_ASSERT(a_no_take_full, !(out_valid && !out_ready) || !in_ready, "request taken while full")
endmodule

bind keyed_fixed_window_rate_limiter kfwrl_checker u_kfwrl_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .blocked(blocked),
	.retry_secs(retry_secs)
);
